// ===== rtl/sfb_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// sfb_pkg
// Shared types and constants of the sensor frame builder: frame layout,
// job record passed from the front part to the back part.
// ----------------------------------------------------------------------------
package sfb_pkg;

  // frame layout
  localparam int unsigned FRAME_LEN = 14;
  localparam int unsigned POS_W     = 4;
  localparam logic [7:0]  SYNC_1    = 8'hB5;
  localparam logic [7:0]  SYNC_2    = 8'h62;
  localparam logic [7:0]  LEN_LOW   = 8'h06;
  localparam logic [7:0]  LEN_HIGH  = 8'h00;

  // byte positions inside a frame
  localparam logic [POS_W-1:0] POS_SYNC_1   = 4'd0;
  localparam logic [POS_W-1:0] POS_SYNC_2   = 4'd1;
  localparam logic [POS_W-1:0] POS_CLASS    = 4'd2;
  localparam logic [POS_W-1:0] POS_ID       = 4'd3;
  localparam logic [POS_W-1:0] POS_LEN_LOW  = 4'd4;
  localparam logic [POS_W-1:0] POS_LEN_HIGH = 4'd5;
  localparam logic [POS_W-1:0] POS_DATA_0   = 4'd6;
  localparam logic [POS_W-1:0] POS_DATA_1   = 4'd7;
  localparam logic [POS_W-1:0] POS_DATA_2   = 4'd8;
  localparam logic [POS_W-1:0] POS_DATA_3   = 4'd9;
  localparam logic [POS_W-1:0] POS_DATA_4   = 4'd10;
  localparam logic [POS_W-1:0] POS_DATA_5   = 4'd11;
  localparam logic [POS_W-1:0] POS_CK_A     = 4'd12;
  localparam logic [POS_W-1:0] POS_CK_B     = 4'd13;

  // field widths
  localparam int unsigned SLOT_W      = 4;   // holds any slot number up to 15
  localparam int unsigned SLOT_OUT_W  = 3;
  localparam int unsigned ERR_W       = 4;
  localparam int unsigned RCOUNT_W    = 16;
  localparam int unsigned DATA_BYTES  = 6;
  localparam logic [ERR_W-1:0]    ERR_MAX    = 4'hF;
  localparam logic [RCOUNT_W-1:0] RCOUNT_MAX = 16'hFFFF;

  // item op codes
  typedef enum logic [1:0] {
    OP_GOOD    = 2'd0,
    OP_FAIL    = 2'd1,
    OP_RELEASE = 2'd2,
    OP_UNUSED  = 2'd3
  } op_t;

  // configuration register indexes
  typedef enum logic [1:0] {
    CFG_CLASS = 2'd0,
    CFG_ID    = 2'd1,
    CFG_LIMIT = 2'd2,
    CFG_NONE  = 2'd3
  } cfg_idx_t;

  // kind of work handed to the back part
  typedef enum logic [1:0] {
    JOB_FRAME   = 2'd0,
    JOB_DROP    = 2'd1,
    JOB_RESTART = 2'd2
  } job_kind_t;

  typedef struct packed {
    job_kind_t                           kind;
    logic [SLOT_W-1:0]                   slot;
    logic [DATA_BYTES-1:0][7:0]          data;   // entry 0 is x_low
    logic [RCOUNT_W-1:0]                 rcount;
  } job_t;

  // queue depth between front and back
  localparam int unsigned QUEUE_DEPTH = 2;

endpackage
`default_nettype wire

// ===== rtl/sfb_front.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// sfb_front
// Accepts items, claims and releases send slots, keeps the error and
// restart counters and hands one job per result-bearing item to the queue.
// ----------------------------------------------------------------------------
module sfb_front #(
  parameter int unsigned SLOT_COUNT = 6
) (
  input  wire                          clk,
  input  wire                          rst,
  input  wire                          accept,
  input  wire  [1:0]                   op,
  input  wire  [sfb_pkg::DATA_BYTES-1:0][7:0] data,
  input  wire  [2:0]                   slot_to_free,
  input  wire  [sfb_pkg::ERR_W-1:0]    error_limit,
  output logic                         push,
  output sfb_pkg::job_t                job
);

  logic [SLOT_COUNT-1:0]            slot_busy;
  logic [SLOT_COUNT-1:0]            slot_busy_next;
  logic [sfb_pkg::ERR_W-1:0]        error_count;
  logic [sfb_pkg::ERR_W-1:0]        error_count_next;
  logic [sfb_pkg::RCOUNT_W-1:0]     restarts_done;
  logic [sfb_pkg::RCOUNT_W-1:0]     restarts_done_next;
  logic [sfb_pkg::SLOT_W-1:0]       found;
  logic                             found_any;
  logic [sfb_pkg::ERR_W-1:0]        err_inc;

  // highest-numbered free slot: later iterations win
  always_comb begin
    found     = '0;
    found_any = 1'b0;
    for (int j = 0; j < SLOT_COUNT; j++) begin
      if (!slot_busy[j]) begin
        found     = sfb_pkg::SLOT_W'(j);
        found_any = 1'b1;
      end
    end
  end

  assign err_inc = (error_count < sfb_pkg::ERR_MAX) ? error_count + 1'b1 : error_count;

  always_comb begin
    slot_busy_next     = slot_busy;
    error_count_next   = error_count;
    restarts_done_next = restarts_done;
    push               = 1'b0;
    job.kind           = sfb_pkg::JOB_FRAME;
    job.slot           = found;
    job.data           = data;
    job.rcount         = restarts_done;
    if (accept) begin
      unique case (sfb_pkg::op_t'(op))
        sfb_pkg::OP_GOOD: begin
          push = 1'b1;
          if (found_any) begin
            for (int j = 0; j < SLOT_COUNT; j++) begin
              if (found == sfb_pkg::SLOT_W'(j)) slot_busy_next[j] = 1'b1;
            end
          end else begin
            job.kind = sfb_pkg::JOB_DROP;
          end
        end
        sfb_pkg::OP_FAIL: begin
          if (err_inc >= error_limit) begin
            error_count_next = '0;
            if (restarts_done != sfb_pkg::RCOUNT_MAX) begin
              restarts_done_next = restarts_done + 1'b1;
            end
            push       = 1'b1;
            job.kind   = sfb_pkg::JOB_RESTART;
            job.rcount = restarts_done_next;
          end else begin
            error_count_next = err_inc;
          end
        end
        sfb_pkg::OP_RELEASE: begin
          for (int j = 0; j < SLOT_COUNT; j++) begin
            if ({1'b0, slot_to_free} == sfb_pkg::SLOT_W'(j)) slot_busy_next[j] = 1'b0;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_busy     <= '0;
      error_count   <= '0;
      restarts_done <= '0;
    end else begin
      slot_busy     <= slot_busy_next;
      error_count   <= error_count_next;
      restarts_done <= restarts_done_next;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/sfb_queue.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// sfb_queue
// Short job queue between the front and the back part.
// ----------------------------------------------------------------------------
module sfb_queue (
  input  wire            clk,
  input  wire            rst,
  input  wire            push,
  input  sfb_pkg::job_t  push_job,
  input  wire            pop,
  output logic           full,
  output logic           not_empty,
  output sfb_pkg::job_t  head
);

  localparam int unsigned PTR_W = (sfb_pkg::QUEUE_DEPTH > 1) ? $clog2(sfb_pkg::QUEUE_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(sfb_pkg::QUEUE_DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(sfb_pkg::QUEUE_DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(sfb_pkg::QUEUE_DEPTH);

  sfb_pkg::job_t     entries [sfb_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0]  wr_ptr;
  logic [PTR_W-1:0]  rd_ptr;
  logic [CNT_W-1:0]  count;

  assign full      = (count == CNT_FULL);
  assign not_empty = (count != '0);
  assign head      = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) entries[wr_ptr] <= push_job;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= (wr_ptr == PTR_LAST) ? '0 : wr_ptr + 1'b1;
      if (pop)  rd_ptr <= (rd_ptr == PTR_LAST) ? '0 : rd_ptr + 1'b1;
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

// ===== rtl/sfb_back.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// sfb_back
// Byte sequencer: walks the queue head job one result per cycle unless the
// output stalls, builds the running checksums and holds the output register.
// ----------------------------------------------------------------------------
module sfb_back (
  input  wire                           clk,
  input  wire                           rst,
  input  wire                           job_valid,
  input  sfb_pkg::job_t                 job,
  input  wire  [7:0]                    message_class,
  input  wire  [7:0]                    message_id,
  output logic                          pop,
  output logic                          out_valid,
  input  wire                           out_ready,
  output logic [7:0]                    frame_byte,
  output logic                          byte_valid,
  output logic [sfb_pkg::SLOT_OUT_W-1:0] slot,
  output logic                          last,
  output logic                          dropped,
  output logic                          restart,
  output logic [sfb_pkg::RCOUNT_W-1:0]  restart_count
);

  logic [sfb_pkg::POS_W-1:0] pos;
  logic [7:0]                ck_a;
  logic [7:0]                ck_b;
  logic [7:0]                cur_byte;
  logic [7:0]                ck_a_next;
  logic                      advance;
  logic                      is_frame;
  logic                      cur_last;
  logic                      in_sum;

  assign advance  = job_valid && (!out_valid || out_ready);
  assign is_frame = (job.kind == sfb_pkg::JOB_FRAME);
  assign cur_last = !is_frame || (pos == sfb_pkg::POS_CK_B);
  assign pop      = advance && cur_last;
  assign in_sum   = (pos >= sfb_pkg::POS_CLASS) && (pos <= sfb_pkg::POS_DATA_5);
  assign ck_a_next = ck_a + cur_byte;

  always_comb begin
    unique case (pos)
      sfb_pkg::POS_SYNC_1:   cur_byte = sfb_pkg::SYNC_1;
      sfb_pkg::POS_SYNC_2:   cur_byte = sfb_pkg::SYNC_2;
      sfb_pkg::POS_CLASS:    cur_byte = message_class;
      sfb_pkg::POS_ID:       cur_byte = message_id;
      sfb_pkg::POS_LEN_LOW:  cur_byte = sfb_pkg::LEN_LOW;
      sfb_pkg::POS_LEN_HIGH: cur_byte = sfb_pkg::LEN_HIGH;
      sfb_pkg::POS_DATA_0:   cur_byte = job.data[0];
      sfb_pkg::POS_DATA_1:   cur_byte = job.data[1];
      sfb_pkg::POS_DATA_2:   cur_byte = job.data[2];
      sfb_pkg::POS_DATA_3:   cur_byte = job.data[3];
      sfb_pkg::POS_DATA_4:   cur_byte = job.data[4];
      sfb_pkg::POS_DATA_5:   cur_byte = job.data[5];
      sfb_pkg::POS_CK_A:     cur_byte = ck_a;
      sfb_pkg::POS_CK_B:     cur_byte = ck_b;
      default:               cur_byte = '0;
    endcase
  end

  // sequencer and checksum state
  always_ff @(posedge clk) begin
    if (rst) begin
      pos  <= '0;
      ck_a <= '0;
      ck_b <= '0;
    end else if (advance) begin
      if (cur_last) begin
        pos  <= '0;
        ck_a <= '0;
        ck_b <= '0;
      end else begin
        pos <= pos + 1'b1;
        if (in_sum) begin
          ck_a <= ck_a_next;
          ck_b <= ck_b + ck_a_next;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // payload of the output register
  always_ff @(posedge clk) begin
    if (advance) begin
      frame_byte    <= is_frame ? cur_byte : 8'h00;
      byte_valid    <= is_frame;
      slot          <= is_frame ? job.slot[sfb_pkg::SLOT_OUT_W-1:0] : '0;
      last          <= cur_last;
      dropped       <= (job.kind == sfb_pkg::JOB_DROP);
      restart       <= (job.kind == sfb_pkg::JOB_RESTART);
      restart_count <= job.rcount;
    end
  end

`ifndef SYNTHESIS
  a_pos_range: assert property (@(posedge clk) disable iff (rst)
    pos <= sfb_pkg::POS_CK_B)
    else $error("byte position past end of frame");

  a_single_at_start: assert property (@(posedge clk) disable iff (rst)
    (job_valid && !is_frame) |-> (pos == '0))
    else $error("single-result job found mid-frame");

  a_no_byte_last: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !byte_valid) |-> (last && (dropped != restart)))
    else $error("non-frame result is not a lone dropped or restart result");

  a_frame_clean: assert property (@(posedge clk) disable iff (rst)
    (advance && !cur_last) |=> (out_valid && byte_valid && !last))
    else $error("frame byte lost its flags");
`endif

endmodule
`default_nettype wire

// ===== rtl/sensor_frame_builder_with_slots_unit.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// sensor_frame_builder_with_slots_unit
// Builds 14-byte sensor frames with a Fletcher checksum into free send
// slots, counts failed reads and flags restarts.
// ----------------------------------------------------------------------------
//  channel   handshake                  payload
//  --------  -------------------------  --------------------------------------
//  input     in_valid / in_ready        op, x/y/z low/high bytes, slot_to_free
//  output    out_valid / out_ready      frame_byte, byte_valid, slot, last,
//                                       dropped, restart, restart_count
//  config    cfg_valid / cfg_ready      cfg_index, cfg_data
//
//  a good read with a free slot gives 14 results, one per cycle while the
//  output is not stalled, from the back sequencer's byte walk; dropped and
//  restart items give one result; the front keeps classifying into the
//  two-entry job queue while the back part still streams a frame
//  reset is synchronous: all slots free, counters zero, config at defaults
//  a stalled output holds the back part; the front stalls only on a full queue
// ----------------------------------------------------------------------------
module sensor_frame_builder_with_slots_unit #(
  parameter int unsigned SLOT_COUNT = 6
) (
  input  wire         clk,
  input  wire         rst,
  // input items
  input  wire         in_valid,
  output logic        in_ready,
  input  wire  [1:0]  op,
  input  wire  [7:0]  x_low,
  input  wire  [7:0]  x_high,
  input  wire  [7:0]  y_low,
  input  wire  [7:0]  y_high,
  input  wire  [7:0]  z_low,
  input  wire  [7:0]  z_high,
  input  wire  [2:0]  slot_to_free,
  // result items
  output logic        out_valid,
  input  wire         out_ready,
  output logic [7:0]  frame_byte,
  output logic        byte_valid,
  output logic [2:0]  slot,
  output logic        last,
  output logic        dropped,
  output logic        restart,
  output logic [15:0] restart_count,
  // configuration writes
  input  wire         cfg_valid,
  output logic        cfg_ready,
  input  wire  [1:0]  cfg_index,
  input  wire  [7:0]  cfg_data
);

  logic [7:0]                  message_class;
  logic [7:0]                  message_id;
  logic [sfb_pkg::ERR_W-1:0]   error_limit;

  logic                        in_accept;
  logic                        push;
  sfb_pkg::job_t               push_job;
  logic                        pop;
  logic                        q_full;
  logic                        q_not_empty;
  sfb_pkg::job_t               head;
  logic [sfb_pkg::DATA_BYTES-1:0][7:0] data;

  // configuration registers, always ready
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      message_class <= 8'd17;
      message_id    <= 8'd1;
      error_limit   <= 4'd10;
    end else if (cfg_valid) begin
      unique case (sfb_pkg::cfg_idx_t'(cfg_index))
        sfb_pkg::CFG_CLASS: message_class <= cfg_data;
        sfb_pkg::CFG_ID:    message_id    <= cfg_data;
        sfb_pkg::CFG_LIMIT: error_limit   <= cfg_data[sfb_pkg::ERR_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // front accepts whenever a job would still fit
  assign in_ready  = !q_full;
  assign in_accept = in_valid && in_ready;

  // payload bytes in frame order
  assign data = {z_high, z_low, y_high, y_low, x_high, x_low};

  sfb_front #(
    .SLOT_COUNT (SLOT_COUNT)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .accept       (in_accept),
    .op           (op),
    .data         (data),
    .slot_to_free (slot_to_free),
    .error_limit  (error_limit),
    .push         (push),
    .job          (push_job)
  );

  sfb_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_job  (push_job),
    .pop       (pop),
    .full      (q_full),
    .not_empty (q_not_empty),
    .head      (head)
  );

  // back part streams the head job into the output register
  sfb_back u_back (
    .clk           (clk),
    .rst           (rst),
    .job_valid     (q_not_empty),
    .job           (head),
    .message_class (message_class),
    .message_id    (message_id),
    .pop           (pop),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .frame_byte    (frame_byte),
    .byte_valid    (byte_valid),
    .slot          (slot),
    .last          (last),
    .dropped       (dropped),
    .restart       (restart),
    .restart_count (restart_count)
  );

endmodule
`default_nettype wire
